FILE: rtl/core/tcaf_pkg.sv
// Shared types and constants for the two-class age-ordered FIFO.
`timescale 1ns / 1ps
`default_nettype none
package tcaf_pkg;

	localparam int DefDepth    = 16;
	localparam int DefIdWidth  = 16;
	localparam int DefTagWidth = 8;
	localparam int ItemIdW     = 16;

	typedef enum logic [1:0] {
		FN_ENQ        = 2'd0,
		FN_DEQ_OLDEST = 2'd1,
		FN_DEQ_C0     = 2'd2,
		FN_DEQ_C1     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_PICK = 1'b1
	} fsm_t;

	typedef struct packed {
		logic push;
		logic rd;
		logic pop;
	} qctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage
`default_nettype wire

FILE: rtl/core/tcaf_req_if.sv
// Request channel: operation code, class and identifier of one beat.
`timescale 1ns / 1ps
`default_nettype none
interface tcaf_req_if;
	logic                                  valid;
	logic                                  ready;
	tcaf_pkg::func_t                       func;
	logic                                  item_class;
	logic [tcaf_pkg::ItemIdW-1:0]          item_id;

	modport source (output valid, output func, output item_class, output item_id,
		input ready);
	modport sink (input valid, input func, input item_class, input item_id,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tcaf_rsp_if.sv
// Response channel: status, class and identifier of one beat.
`timescale 1ns / 1ps
`default_nettype none
interface tcaf_rsp_if;
	logic                                  valid;
	logic                                  ready;
	tcaf_pkg::status_t                     status;
	logic                                  out_class;
	logic [tcaf_pkg::ItemIdW-1:0]          out_id;

	modport source (output valid, output status, output out_class, output out_id,
		input ready);
	modport sink (input valid, input status, input out_class, input out_id,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tcaf_queue.sv
// One class queue: circular store in a synchronous memory with head and fill count.
`timescale 1ns / 1ps
`default_nettype none
module tcaf_queue #(
	parameter int DEPTH     = tcaf_pkg::DefDepth,
	parameter int ID_WIDTH  = tcaf_pkg::DefIdWidth,
	parameter int TAG_WIDTH = tcaf_pkg::DefTagWidth
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  tcaf_pkg::qctl_t        ctl,
	input  wire  [ID_WIDTH-1:0]    wr_id,
	input  wire  [TAG_WIDTH-1:0]   wr_tag,
	output logic [ID_WIDTH-1:0]    rd_id,
	output logic [TAG_WIDTH-1:0]   rd_tag,
	output tcaf_pkg::qstat_t       stat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ID_WIDTH + TAG_WIDTH;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_s1;
	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail;

	assign tail_sum = {1'b0, head_q} + (AW+1)'(fill_q);
	assign tail = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
		: tail_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail] <= {wr_tag, wr_id};
		end
		if (ctl.rd) begin
			rd_s1 <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (ctl.push && !ctl.pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (ctl.pop && !ctl.push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	assign rd_id      = rd_s1[ID_WIDTH-1:0];
	assign rd_tag     = rd_s1[EW-1:ID_WIDTH];
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == CW'(DEPTH));
endmodule
`default_nettype wire

FILE: rtl/core/two_class_age_ordered_fifo_core.sv
// Top level of the two-class age-ordered FIFO.
// Usage:
//   req carries one operation per beat: enqueue of item_id into the queue of
//   item_class, dequeue of a named class, or dequeue of the older head of
//   the two classes. Every request beat yields exactly one rsp beat with
//   status (ok, empty, full), the class and the identifier popped.
//   Each enqueue tags its entry with a shared wrapping arrival counter; the
//   oldest-of-either dequeue compares the two head tags modulo the counter.
// Timing and flow:
//   Enqueue: the response is registered in the cycle after the request beat;
//   one enqueue per cycle while the output register is free. Dequeue: the
//   request reads both class heads from the class memories, then the PICK state
//   registers the response once the output is free; no request is taken in PICK.
// Reset: arst_n clears heads, fill counts, arrival counter, state and rsp.valid;
//   rsp fields and memories are not reset; memory data is used only when filled.
// Stall: the response sits in an output register until rsp.ready; a new
//   request is taken while the held response is being taken in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module two_class_age_ordered_fifo_core #(
	parameter int DEPTH     = tcaf_pkg::DefDepth,
	parameter int ID_WIDTH  = tcaf_pkg::DefIdWidth,
	parameter int TAG_WIDTH = tcaf_pkg::DefTagWidth
) (
	input wire         clk,
	input wire         arst_n,
	tcaf_req_if.sink   req,
	tcaf_rsp_if.source rsp
);
	tcaf_pkg::fsm_t    state_q, state_d;
	tcaf_pkg::func_t   func_q;
	tcaf_pkg::qctl_t   ctl0, ctl1;
	tcaf_pkg::qstat_t  stat0, stat1;
	tcaf_pkg::status_t status_q, status_d;

	logic [TAG_WIDTH-1:0]        tag_q;
	logic [ID_WIDTH-1:0]         id_in;
	logic [ID_WIDTH-1:0]         rd_id0, rd_id1;
	logic [TAG_WIDTH-1:0]        rd_tag0, rd_tag1, tag_diff;
	logic [tcaf_pkg::ItemIdW-1:0] id_q, id_d;
	logic                        ov_q, class_q, class_d;
	logic                        out_free, accept, load, pick, older0, tag_inc;

	assign id_in    = ID_WIDTH'(req.item_id);
	assign out_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == tcaf_pkg::FSM_IDLE) && out_free;
	assign accept   = req.valid && req.ready;

	assign tag_diff = rd_tag1 - rd_tag0;
	assign older0   = (tag_diff != '0) && !tag_diff[TAG_WIDTH-1];

	always_comb begin
		state_d  = state_q;
		ctl0     = '0;
		ctl1     = '0;
		load     = 1'b0;
		status_d = tcaf_pkg::STS_OK;
		class_d  = 1'b0;
		id_d     = '0;
		tag_inc  = 1'b0;
		pick     = 1'b0;
		unique case (state_q)
			tcaf_pkg::FSM_IDLE: begin
				if (accept) begin
					if (req.func == tcaf_pkg::FN_ENQ) begin
						load = 1'b1;
						if (req.item_class ? stat1.full : stat0.full) begin
							status_d = tcaf_pkg::STS_FULL;
						end else begin
							tag_inc   = 1'b1;
							ctl0.push = !req.item_class;
							ctl1.push = req.item_class;
						end
					end else begin
						ctl0.rd = 1'b1;
						ctl1.rd = 1'b1;
						state_d = tcaf_pkg::FSM_PICK;
					end
				end
			end
			tcaf_pkg::FSM_PICK: begin
				case (func_q)
					tcaf_pkg::FN_DEQ_C0: pick = 1'b0;
					tcaf_pkg::FN_DEQ_C1: pick = 1'b1;
					default: begin
						if (stat0.empty) begin
							pick = 1'b1;
						end else if (stat1.empty) begin
							pick = 1'b0;
						end else begin
							pick = !older0;
						end
					end
				endcase
				if (out_free) begin
					load    = 1'b1;
					state_d = tcaf_pkg::FSM_IDLE;
					if (pick ? stat1.empty : stat0.empty) begin
						status_d = tcaf_pkg::STS_EMPTY;
					end else begin
						class_d  = pick;
						id_d     = tcaf_pkg::ItemIdW'(pick ? rd_id1 : rd_id0);
						ctl0.pop = !pick;
						ctl1.pop = pick;
					end
				end
			end
			default: state_d = tcaf_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcaf_pkg::FSM_IDLE;
			tag_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tag_inc) begin
				tag_q <= tag_q + TAG_WIDTH'(1);
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
		end
		if (load) begin
			status_q <= status_d;
			class_q  <= class_d;
			id_q     <= id_d;
		end
	end

	tcaf_queue #(
		.DEPTH     (DEPTH),
		.ID_WIDTH  (ID_WIDTH),
		.TAG_WIDTH (TAG_WIDTH)
	) u_queue0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl0),
		.wr_id  (id_in),
		.wr_tag (tag_q),
		.rd_id  (rd_id0),
		.rd_tag (rd_tag0),
		.stat   (stat0)
	);

	tcaf_queue #(
		.DEPTH     (DEPTH),
		.ID_WIDTH  (ID_WIDTH),
		.TAG_WIDTH (TAG_WIDTH)
	) u_queue1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl1),
		.wr_id  (id_in),
		.wr_tag (tag_q),
		.rd_id  (rd_id1),
		.rd_tag (rd_tag1),
		.stat   (stat1)
	);

	assign rsp.valid     = ov_q;
	assign rsp.status    = status_q;
	assign rsp.out_class = class_q;
	assign rsp.out_id    = id_q;
endmodule
`default_nettype wire

FILE: dv/two_class_age_ordered_fifo_core_tb.sv
// Self-checking testbench for the two-class age-ordered FIFO: directed, tag wrap, random.
`timescale 1ns / 1ps
module two_class_age_ordered_fifo_core_tb;

	localparam int DEPTH     = tcaf_pkg::DefDepth;
	localparam int TAG_WIDTH = tcaf_pkg::DefTagWidth;
	localparam int TAG_HALF  = 1 << (TAG_WIDTH - 1);
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		tcaf_pkg::func_t                func;
		logic                           item_class;
		logic [tcaf_pkg::ItemIdW-1:0]   item_id;
	} fifo_req_t;

	typedef struct packed {
		tcaf_pkg::status_t              status;
		logic                           out_class;
		logic [tcaf_pkg::ItemIdW-1:0]   out_id;
	} fifo_rsp_t;

	logic clk;
	logic arst_n;

	tcaf_req_if req ();
	tcaf_rsp_if rsp ();

	two_class_age_ordered_fifo_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	fifo_req_t req_backlog[$];
	fifo_rsp_t pending_rsps[$];

	// shadow of the two class queues
	logic [tcaf_pkg::ItemIdW-1:0] shadow_id  [2][DEPTH];
	logic [TAG_WIDTH-1:0]         shadow_tag [2][DEPTH];
	int                           shadow_head[2];
	int                           shadow_fill[2];
	logic [TAG_WIDTH-1:0]         arrival_tag;

	int cycles;
	int errors;
	int n_req, n_enq, n_full, n_pop, n_empty, n_age, n_tie, n_wrap;
	logic calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic fifo_rsp_t fifo_outcome(input tcaf_pkg::func_t fn, input logic cls,
		input logic [tcaf_pkg::ItemIdW-1:0] id);
		fifo_rsp_t r;
		int pick;
		int tail;
		logic [TAG_WIDTH-1:0] diff;
		r = '{status: tcaf_pkg::STS_OK, out_class: 1'b0, out_id: '0};
		n_req++;
		if (fn == tcaf_pkg::FN_ENQ) begin
			if (shadow_fill[cls] == DEPTH) begin
				r.status = tcaf_pkg::STS_FULL;
				n_full++;
			end else begin
				tail = (shadow_head[cls] + shadow_fill[cls]) % DEPTH;
				shadow_id[cls][tail]  = id;
				shadow_tag[cls][tail] = arrival_tag;
				shadow_fill[cls]++;
				arrival_tag = arrival_tag + 1'b1;
				n_enq++;
			end
		end else begin
			case (fn)
				tcaf_pkg::FN_DEQ_C0: pick = 0;
				tcaf_pkg::FN_DEQ_C1: pick = 1;
				default: begin
					if (shadow_fill[0] == 0) begin
						pick = 1;
					end else if (shadow_fill[1] == 0) begin
						pick = 0;
					end else begin
						diff = shadow_tag[1][shadow_head[1]]
							- shadow_tag[0][shadow_head[0]];
						n_age++;
						if (diff == 0) n_tie++;
						else if (diff >= TAG_HALF) n_wrap++;
						pick = (diff != 0 && diff < TAG_HALF) ? 0 : 1;
					end
				end
			endcase
			if (shadow_fill[pick] == 0) begin
				r.status = tcaf_pkg::STS_EMPTY;
				n_empty++;
			end else begin
				r.out_id    = shadow_id[pick][shadow_head[pick]];
				r.out_class = pick[0];
				shadow_head[pick] = (shadow_head[pick] + 1) % DEPTH;
				shadow_fill[pick]--;
				n_pop++;
			end
		end
		return r;
	endfunction

	task automatic add_req(input tcaf_pkg::func_t fn, input logic cls,
		input logic [tcaf_pkg::ItemIdW-1:0] id);
		req_backlog.push_back('{func: fn, item_class: cls, item_id: id});
	endtask

	function automatic logic [tcaf_pkg::ItemIdW-1:0] rand_id();
		return tcaf_pkg::ItemIdW'($urandom_range(0, 65535));
	endfunction

	function automatic logic rand_cls();
		return 1'($urandom_range(0, 1));
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		fifo_req_t nxt;
		if (!arst_n) begin
			req.valid      <= 1'b0;
			req.func       <= tcaf_pkg::FN_ENQ;
			req.item_class <= 1'b0;
			req.item_id    <= '0;
		end else begin
			if (req.valid && req.ready)
				pending_rsps.push_back(fifo_outcome(req.func, req.item_class, req.item_id));
			if (!req.valid || req.ready) begin
				if (req_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
					nxt = req_backlog.pop_front();
					req.valid      <= 1'b1;
					req.func       <= nxt.func;
					req.item_class <= nxt.item_class;
					req.item_id    <= nxt.item_id;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		fifo_rsp_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_rsps.size() == 0) begin
					$display("%0t: unexpected beat: status %0d class %0d id %h", $time,
						rsp.status, rsp.out_class, rsp.out_id);
					errors++;
				end else begin
					want = pending_rsps.pop_front();
					if (want.status != rsp.status || want.out_class != rsp.out_class ||
						want.out_id != rsp.out_id) begin
						$display("%0t: mismatch: expected status %0d class %0d id %h,",
							$time, want.status, want.out_class, want.out_id,
							" got status %0d class %0d id %h",
							rsp.status, rsp.out_class, rsp.out_id);
						errors++;
					end
				end
			end
			rsp.ready <= calm || ($urandom_range(0, 99) >= 11);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		calm   <= (cycles >= 300 && cycles < 700);
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats outstanding", $time, pending_rsps.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int len;
		int enq_pct;
		int c1_pct;
		int sweep;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.func       = tcaf_pkg::FN_ENQ;
		req.item_class = 1'b0;
		req.item_id    = '0;
		rsp.ready      = 1'b0;
		cycles = 0;
		errors = 0;
		calm   = 1'b0;
		n_req = 0; n_enq = 0; n_full = 0; n_pop = 0; n_empty = 0;
		n_age = 0; n_tie = 0; n_wrap = 0;
		shadow_head = '{0, 0};
		shadow_fill = '{0, 0};
		arrival_tag = '0;

		// directed: empty dequeues, id extremes, class 0 overflow, mixed pops
		add_req(tcaf_pkg::FN_DEQ_OLDEST, 1'b1, 16'hffff);
		add_req(tcaf_pkg::FN_DEQ_C0, 1'b0, 16'h0000);
		add_req(tcaf_pkg::FN_DEQ_C1, 1'b1, 16'hffff);
		add_req(tcaf_pkg::FN_ENQ, 1'b1, 16'hffff);
		add_req(tcaf_pkg::FN_ENQ, 1'b0, 16'h0000);
		for (int i = 1; i < DEPTH; i++)
			add_req(tcaf_pkg::FN_ENQ, 1'b0, (i % 2) ? 16'haaaa ^ tcaf_pkg::ItemIdW'(i)
				: 16'h5555 ^ tcaf_pkg::ItemIdW'(i));
		add_req(tcaf_pkg::FN_ENQ, 1'b0, 16'hbeef);
		add_req(tcaf_pkg::FN_DEQ_OLDEST, 1'b0, 16'h0000);
		add_req(tcaf_pkg::FN_DEQ_OLDEST, 1'b1, 16'hffff);
		add_req(tcaf_pkg::FN_DEQ_C1, 1'b0, 16'h1234);
		add_req(tcaf_pkg::FN_DEQ_C0, 1'b1, 16'h4321);

		// tag sweep: one class 0 entry stays at the head while class 1 cycles
		// through a full lap of the arrival counter
		repeat (DEPTH + 1) add_req(tcaf_pkg::FN_DEQ_C0, rand_cls(), rand_id());
		repeat (DEPTH + 1) add_req(tcaf_pkg::FN_DEQ_C1, rand_cls(), rand_id());
		add_req(tcaf_pkg::FN_ENQ, 1'b0, rand_id());
		sweep = (1 << TAG_WIDTH) + $urandom_range(0, 16);
		for (int k = 1; k <= sweep; k++) begin
			add_req(tcaf_pkg::FN_ENQ, 1'b1, rand_id());
			if (k >= TAG_HALF && (k == TAG_HALF || k == (1 << TAG_WIDTH) ||
				$urandom_range(0, 3) == 0))
				add_req(tcaf_pkg::FN_DEQ_OLDEST, rand_cls(), rand_id());
			else
				add_req(tcaf_pkg::FN_DEQ_C1, rand_cls(), rand_id());
		end
		add_req(tcaf_pkg::FN_DEQ_OLDEST, 1'b0, rand_id());
		add_req(tcaf_pkg::FN_DEQ_OLDEST, 1'b1, rand_id());

		// random bursts with varying fill pressure and class mix
		while (req_backlog.size() < 700) begin
			len = $urandom_range(20, 50);
			case ($urandom_range(0, 2))
				0: enq_pct = 20;
				1: enq_pct = 50;
				default: enq_pct = 85;
			endcase
			c1_pct = $urandom_range(10, 90);
			repeat (len) begin
				if ($urandom_range(0, 99) < enq_pct)
					add_req(tcaf_pkg::FN_ENQ, $urandom_range(0, 99) < c1_pct, rand_id());
				else
					add_req(tcaf_pkg::func_t'($urandom_range(1, 3)), rand_cls(), rand_id());
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || req.valid) @(posedge clk);
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d requests: %0d enqueued, %0d refused full, %0d popped, %0d empty.",
			n_req, n_enq, n_full, n_pop, n_empty);
		$display("Age compares with both heads: %0d, equal tags %0d, wrapped %0d.",
			n_age, n_tie, n_wrap);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
